@@ src/esgd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_pkg
// Types and constants shared by the edge swipe gesture detector.
// ----------------------------------------------------------------------------
package esgd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int RES_W      = 12;
  localparam int LIMIT_W    = 16;
  localparam int DIR_W      = 3;
  localparam int NEED_W     = 16;

  // divide by three: (x * 43691) >> 17 is exact for 16-bit x
  localparam int RECIP_SHIFT = 17;
  localparam logic [RECIP_SHIFT-1:0] RECIP_3 = 17'd43691;

  localparam logic [RES_W-1:0]   RESET_WIDTH  = 12'd240;
  localparam logic [RES_W-1:0]   RESET_HEIGHT = 12'd240;
  localparam logic [LIMIT_W-1:0] RESET_LIMIT  = 16'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HRES        = 2'd0,
    REG_VRES        = 2'd1,
    REG_SWIPE_LIMIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UP    = 3'd4
  } dir_t;

  typedef struct packed {
    logic [RES_W-1:0]   hres;
    logic [RES_W-1:0]   vres;
    logic [LIMIT_W-1:0] swipe_limit_ms;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/esgd_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface esgd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [esgd_pkg::CFG_IDX_W-1:0]   index;
  logic [esgd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/esgd_touch_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_touch_if
// Touch sample channel: press flag, coordinates and timestamp.
// ----------------------------------------------------------------------------
interface esgd_touch_if #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
);
  logic                  valid;
  logic                  ready;
  logic                  pressed;
  logic [COORD_BITS-1:0] touch_x;
  logic [COORD_BITS-1:0] touch_y;
  logic [TIME_BITS-1:0]  time_ms;

  modport source (output valid, output pressed, output touch_x, output touch_y,
                  output time_ms, input ready);
  modport sink   (input valid, input pressed, input touch_x, input touch_y,
                  input time_ms, output ready);
endinterface
`default_nettype wire

@@ src/esgd_swipe_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_swipe_if
// Result channel: swipe direction and gesture activity flag.
// ----------------------------------------------------------------------------
interface esgd_swipe_if;
  logic                         valid;
  logic                         ready;
  logic [esgd_pkg::DIR_W-1:0]   swipe_dir;
  logic                         gesture_active;

  modport source (output valid, output swipe_dir, output gesture_active, input ready);
  modport sink   (input valid, input swipe_dir, input gesture_active, output ready);
endinterface
`default_nettype wire

@@ src/esgd_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_cfg
// Screen size and time limit registers, written through the config channel.
// ----------------------------------------------------------------------------
module esgd_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  esgd_cfg_if.sink          cfg,
  output esgd_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hres           <= esgd_pkg::RESET_WIDTH;
      regs.vres           <= esgd_pkg::RESET_HEIGHT;
      regs.swipe_limit_ms <= esgd_pkg::RESET_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        esgd_pkg::REG_HRES: begin
          regs.hres <= cfg.data[esgd_pkg::RES_W-1:0];
        end
        esgd_pkg::REG_VRES: begin
          regs.vres <= cfg.data[esgd_pkg::RES_W-1:0];
        end
        esgd_pkg::REG_SWIPE_LIMIT: begin
          regs.swipe_limit_ms <= cfg.data[esgd_pkg::LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/esgd_track.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_track
// Start point tracking and swipe / activity evaluation for one sample.
// ----------------------------------------------------------------------------
module esgd_track #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic                         pressed,
  input  wire logic [COORD_BITS-1:0]        touch_x,
  input  wire logic [COORD_BITS-1:0]        touch_y,
  input  wire logic [TIME_BITS-1:0]         time_ms,
  input  esgd_pkg::cfg_t                    cfg,
  output logic [esgd_pkg::DIR_W-1:0]        swipe_dir,
  output logic                              gesture_active
);

  localparam int SW = ((COORD_BITS > esgd_pkg::RES_W) ? COORD_BITS : esgd_pkg::RES_W) + 2;
  localparam int CMP_W = ((COORD_BITS > esgd_pkg::NEED_W) ? COORD_BITS
                                                          : esgd_pkg::NEED_W) + 1;
  localparam int PROD_W = esgd_pkg::NEED_W + esgd_pkg::RECIP_SHIFT;

  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [TIME_BITS-1:0]  start_stamp;
  logic                  start_held;
  logic                  prev_pressed;

  logic [TIME_BITS-1:0]       elapsed;
  logic                       in_time;
  logic                       press_edge;
  logic                       release_edge;
  logic signed [SW-1:0]       sx, sy, px, py, w, h, w8, w4, h8, h4;
  logic signed [SW-1:0]       dx, dy;
  logic [SW-1:0]              abs_x, abs_y;
  logic [PROD_W-1:0]          prod;
  logic [esgd_pkg::NEED_W-1:0] need;

  assign elapsed      = time_ms - start_stamp;
  assign in_time      = elapsed < TIME_BITS'(cfg.swipe_limit_ms);
  assign press_edge   = !prev_pressed && pressed;
  assign release_edge = prev_pressed && !pressed && in_time;

  assign sx = $signed(SW'(start_x));
  assign sy = $signed(SW'(start_y));
  assign px = $signed(SW'(touch_x));
  assign py = $signed(SW'(touch_y));
  assign w  = $signed(SW'(cfg.hres));
  assign h  = $signed(SW'(cfg.vres));
  assign w8 = $signed(SW'(cfg.hres >> 3));
  assign w4 = $signed(SW'(cfg.hres >> 2));
  assign h8 = $signed(SW'(cfg.vres >> 3));
  assign h4 = $signed(SW'(cfg.vres >> 2));

  assign dx    = px - sx;
  assign dy    = py - sy;
  assign abs_x = (dx < 0) ? SW'(-dx) : SW'(dx);
  assign abs_y = (dy < 0) ? SW'(-dy) : SW'(dy);

  // only meaningful while in time, so elapsed fits in 16 bits
  assign prod = PROD_W'(elapsed[esgd_pkg::NEED_W-1:0]) * PROD_W'(esgd_pkg::RECIP_3);
  assign need = prod[PROD_W-1:esgd_pkg::RECIP_SHIFT];

  always_comb begin
    swipe_dir = esgd_pkg::DIR_NONE;
    if (release_edge) begin
      if (sx < w8 && dx > w4) begin
        swipe_dir = esgd_pkg::DIR_RIGHT;
      end else if (w - sx < w8 && -dx > w4) begin
        swipe_dir = esgd_pkg::DIR_LEFT;
      end else if (sy < h8 && dy > h4) begin
        swipe_dir = esgd_pkg::DIR_DOWN;
      end else if (h - sy < h8 && -dy > h4) begin
        swipe_dir = esgd_pkg::DIR_UP;
      end
    end
  end

  // a press edge has zero travel, a release edge in time drops the start
  assign gesture_active = start_held && in_time && !press_edge && !release_edge &&
                          ((CMP_W'(abs_x) > CMP_W'(need)) || (CMP_W'(abs_y) > CMP_W'(need)));

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_y      <= '0;
      start_stamp  <= '0;
      start_held   <= 1'b0;
      prev_pressed <= 1'b0;
    end else if (advance) begin
      prev_pressed <= pressed;
      if (press_edge) begin
        start_x     <= touch_x;
        start_y     <= touch_y;
        start_stamp <= time_ms;
        start_held  <= 1'b1;
      end else if (release_edge) begin
        start_held <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/edge_swipe_gesture_detector.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edge_swipe_gesture_detector
// Detects edge swipes and fast movements from a stream of touch samples.
//
//   channel  role    handshake     payload
//   touch    sink    valid/ready   pressed, touch_x, touch_y, time_ms
//   result   source  valid/ready   swipe_dir, gesture_active
//   cfg      sink    valid/ready   index, data (ready always high)
//
// each item passes an input register and a result register, in that order;
// one item per cycle is sustained while the result is not stalled; the
// start state updates as an item moves from the input register to the result
// reset is synchronous: registers return to 240 x 240 and 400 ms, no start held
// a stalled result holds the input register; the input stage still fills
// ----------------------------------------------------------------------------
module edge_swipe_gesture_detector #(
  parameter int COORD_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  esgd_cfg_if.sink       cfg,
  esgd_touch_if.sink     touch,
  esgd_swipe_if.source   result
);

  esgd_pkg::cfg_t regs;

  logic                  s1_valid;
  logic                  s1_pressed;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [TIME_BITS-1:0]  s1_time;

  logic                          res_valid;
  logic [esgd_pkg::DIR_W-1:0]    res_dir;
  logic                          res_active;

  logic                          advance;
  logic                          take;
  logic [esgd_pkg::DIR_W-1:0]    dir_next;
  logic                          active_next;

  esgd_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  esgd_track #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .pressed        (s1_pressed),
    .touch_x        (s1_x),
    .touch_y        (s1_y),
    .time_ms        (s1_time),
    .cfg            (regs),
    .swipe_dir      (dir_next),
    .gesture_active (active_next)
  );

  assign advance     = s1_valid && (!res_valid || result.ready);
  assign touch.ready = !s1_valid || advance;
  assign take        = touch.valid && touch.ready;

  assign result.valid          = res_valid;
  assign result.swipe_dir      = res_dir;
  assign result.gesture_active = res_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pressed <= touch.pressed;
      s1_x       <= touch.touch_x;
      s1_y       <= touch.touch_y;
      s1_time    <= touch.time_ms;
    end
    if (advance) begin
      res_dir    <= dir_next;
      res_active <= active_next;
    end
  end

endmodule
`default_nettype wire

@@ src/esgd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esgd_checker
// Port-level checks on the result channel of the edge swipe detector.
// ----------------------------------------------------------------------------
module esgd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       res_valid,
  input wire logic                       res_ready,
  input wire logic [esgd_pkg::DIR_W-1:0] swipe_dir,
  input wire logic                       gesture_active
);

  // a result never shows up in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (swipe_dir == esgd_pkg::DIR_NONE || swipe_dir == esgd_pkg::DIR_RIGHT ||
                   swipe_dir == esgd_pkg::DIR_LEFT || swipe_dir == esgd_pkg::DIR_DOWN ||
                   swipe_dir == esgd_pkg::DIR_UP))
    else $error("swipe direction out of range");

  // a reported swipe drops the start, so no activity on that item
  a_swipe_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && swipe_dir != esgd_pkg::DIR_NONE) |-> !gesture_active)
    else $error("gesture active on a swipe item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(swipe_dir) && $stable(gesture_active)))
    else $error("stalled result item changed");

endmodule

bind edge_swipe_gesture_detector esgd_checker u_esgd_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .swipe_dir      (result.swipe_dir),
  .gesture_active (result.gesture_active)
);
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the edge swipe gesture detector. A short table of
// touch samples walks the reset setting (every swipe direction, slow release,
// off-screen start, timestamp wrap), then random gesture runs under several
// register settings, zero and full-scale among them. Typed table rows are checked
// as listed, all else against a behavioural model of the start tracking and swipe decision.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COORD_W   = 12;
  localparam int TIME_W    = 32;
  localparam int COORD_MAX = (1 << COORD_W) - 1;
  localparam logic [esgd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic               pressed;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [TIME_W-1:0]  stamp;
  } sample_t;

  typedef struct packed {
    esgd_pkg::dir_t dir;
    logic           active;
  } swipe_t;

  typedef struct packed {
    sample_t s;
    logic    typed;
    swipe_t  want;
  } row_t;

  localparam int NROWS = 24;
  localparam row_t PLAN [NROWS] = '{
    '{'{1'b0, 12'd0,    12'd0,    32'd0},         1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd10,   12'd100,  32'd1000},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd100,  12'd100,  32'd1100},      1'b1, '{esgd_pkg::DIR_NONE,  1'b1}},
    '{'{1'b0, 12'd100,  12'd100,  32'd1150},      1'b1, '{esgd_pkg::DIR_RIGHT, 1'b0}},
    '{'{1'b1, 12'd235,  12'd120,  32'd2000},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd230,  12'd118,  32'd2050},      1'b0, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd100,  12'd120,  32'd2100},      1'b1, '{esgd_pkg::DIR_LEFT,  1'b0}},
    '{'{1'b1, 12'd120,  12'd5,    32'd3000},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd120,  12'd200,  32'd3200},      1'b1, '{esgd_pkg::DIR_DOWN,  1'b0}},
    '{'{1'b1, 12'd120,  12'd238,  32'd4000},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd120,  12'd10,   32'd4390},      1'b1, '{esgd_pkg::DIR_UP,    1'b0}},
    '{'{1'b1, 12'd5,    12'd5,    32'd5000},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd200,  12'd200,  32'd5400},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd200,  12'd200,  32'd5300},      1'b0, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd0,    12'd0,    32'd5500},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd40,   12'd0,    32'd5600},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd4095, 12'd4095, 32'd6000},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd4000, 12'd100,  32'd6100},      1'b1, '{esgd_pkg::DIR_LEFT,  1'b0}},
    '{'{1'b1, 12'd50,   12'd50,   32'd6120},      1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd4095, 12'd4095, 32'd6130},      1'b0, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd4095, 12'd0,    32'hFFFF_FFF0}, 1'b1, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b1, 12'd4095, 12'd4095, 32'hFFFF_FFFF}, 1'b0, '{esgd_pkg::DIR_NONE,  1'b0}},
    '{'{1'b0, 12'd4095, 12'd4095, 32'h0000_0010}, 1'b1, '{esgd_pkg::DIR_DOWN,  1'b0}},
    '{'{1'b0, 12'd0,    12'd4095, 32'hFFFF_FFFF}, 1'b0, '{esgd_pkg::DIR_NONE,  1'b0}}
  };

  logic clk;
  logic rst;

  esgd_cfg_if                                             cfg ();
  esgd_touch_if #(.COORD_BITS(COORD_W), .TIME_BITS(TIME_W)) touch ();
  esgd_swipe_if                                           result ();

  edge_swipe_gesture_detector #(
    .COORD_BITS(COORD_W),
    .TIME_BITS (TIME_W)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .touch (touch),
    .result(result)
  );

  // model copy of registers and start tracking
  logic [esgd_pkg::RES_W-1:0]   cfg_width;
  logic [esgd_pkg::RES_W-1:0]   cfg_height;
  logic [esgd_pkg::LIMIT_W-1:0] cfg_limit;
  logic [COORD_W-1:0] held_x;
  logic [COORD_W-1:0] held_y;
  logic [TIME_W-1:0]  held_time;
  logic               held_valid;
  logic               was_pressed;

  swipe_t            pending_swipes [$];
  int                mismatches;
  int                results_seen;
  int                sent;
  int                idle_odds;
  logic              line_pressed;
  logic [TIME_W-1:0] tnow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("edge_swipe_gesture_detector regression: fail");
    $finish;
  end

  function automatic swipe_t predict_swipe(sample_t s);
    logic [TIME_W-1:0] elapsed;
    logic              in_time;
    int                w, h, sx, sy, px, py, dx, dy;
    longint            need;
    swipe_t            r;
    elapsed = s.stamp - held_time;
    in_time = elapsed < TIME_W'(cfg_limit);
    px = int'(s.x);
    py = int'(s.y);
    r.dir = esgd_pkg::DIR_NONE;
    r.active = 1'b0;
    if (!was_pressed && s.pressed) begin
      held_x = s.x;
      held_y = s.y;
      held_time = s.stamp;
      held_valid = 1'b1;
    end else if (was_pressed && !s.pressed && in_time) begin
      w = int'(cfg_width);
      h = int'(cfg_height);
      sx = int'(held_x);
      sy = int'(held_y);
      if (sx < w / 8 && px - sx > w / 4) begin
        r.dir = esgd_pkg::DIR_RIGHT;
      end else if (w - sx < w / 8 && sx - px > w / 4) begin
        r.dir = esgd_pkg::DIR_LEFT;
      end else if (sy < h / 8 && py - sy > h / 4) begin
        r.dir = esgd_pkg::DIR_DOWN;
      end else if (h - sy < h / 8 && sy - py > h / 4) begin
        r.dir = esgd_pkg::DIR_UP;
      end
      held_valid = 1'b0;
    end
    if (held_valid && in_time) begin
      need = longint'(elapsed / 3);
      dx = px - int'(held_x);
      dy = py - int'(held_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      r.active = (longint'(dx) > need) || (longint'(dy) > need);
    end
    was_pressed = s.pressed;
    return r;
  endfunction

  function automatic int clip_coord(int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // start point within reach of the low or the high edge of one axis
  function automatic int near_edge(int size, logic far_side);
    int r;
    r = int'($urandom_range(0, size / 8 + 2));
    return clip_coord(far_side ? size - r : r);
  endfunction

  // travel that often sits right at the quarter-screen threshold
  function automatic int swipe_span(int size);
    if ($urandom_range(0, 1) == 0) return size / 4 + int'($urandom_range(0, 2));
    return int'($urandom_range(0, size / 2 + 2));
  endfunction

  function automatic int jitter();
    return int'($urandom_range(0, 8)) - 4;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatches++;
    $display("result %0d: %s expected %0d got %0d", results_seen, what, want_v, got_v);
  endtask

  task automatic drive_sample(sample_t s, logic typed, swipe_t want);
    int     gap;
    swipe_t predicted;
    if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
      touch.valid <= 1'b0;
      gap = int'($urandom_range(1, 15));
      repeat (gap) @(posedge clk);
    end
    touch.valid   <= 1'b1;
    touch.pressed <= s.pressed;
    touch.touch_x <= s.x;
    touch.touch_y <= s.y;
    touch.time_ms <= s.stamp;
    do @(posedge clk); while (touch.ready !== 1'b1);
    predicted = predict_swipe(s);
    pending_swipes.push_back(typed ? want : predicted);
    line_pressed = s.pressed;
    sent++;
  endtask

  task automatic send_touch(logic p, int x, int y, logic [TIME_W-1:0] t);
    sample_t s;
    s.pressed = p;
    s.x = COORD_W'(clip_coord(x));
    s.y = COORD_W'(clip_coord(y));
    s.stamp = t;
    drive_sample(s, 1'b0, '{esgd_pkg::DIR_NONE, 1'b0});
  endtask

  task automatic write_register(logic [esgd_pkg::CFG_IDX_W-1:0] idx,
                                logic [esgd_pkg::CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    case (idx)
      esgd_pkg::REG_HRES:        cfg_width  = value[esgd_pkg::RES_W-1:0];
      esgd_pkg::REG_VRES:        cfg_height = value[esgd_pkg::RES_W-1:0];
      esgd_pkg::REG_SWIPE_LIMIT: cfg_limit  = value[esgd_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(int w, int h, int lim);
    touch.valid <= 1'b0;
    while (pending_swipes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(esgd_pkg::REG_HRES,        {4'($urandom), 12'(w)});
    write_register(esgd_pkg::REG_VRES,        {4'($urandom), 12'(h)});
    write_register(esgd_pkg::REG_SWIPE_LIMIT, 16'(lim));
    write_register(CFG_IDX_SPARE,             16'($urandom));
    cfg.valid <= 1'b0;
  endtask

  task automatic play_gesture();
    int                w, h, sx, sy, ex, ey, dur, n_mid, k;
    logic [TIME_W-1:0] t0;
    w = int'(cfg_width);
    h = int'(cfg_height);
    if (line_pressed)
      send_touch(1'b0, int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)),
                 tnow);
    sx = int'($urandom_range(0, w));
    sy = int'($urandom_range(0, h));
    if ($urandom_range(0, 7) == 0) begin
      sx = int'($urandom_range(0, COORD_MAX));
      sy = int'($urandom_range(0, COORD_MAX));
    end
    ex = sx + jitter();
    ey = sy + jitter();
    case ($urandom_range(0, 4))
      0: begin sx = near_edge(w, 1'b0); ex = sx + swipe_span(w); end
      1: begin sx = near_edge(w, 1'b1); ex = sx - swipe_span(w); end
      2: begin sy = near_edge(h, 1'b0); ey = sy + swipe_span(h); end
      3: begin sy = near_edge(h, 1'b1); ey = sy - swipe_span(h); end
      default: begin
        ex = int'($urandom_range(0, COORD_MAX));
        ey = int'($urandom_range(0, COORD_MAX));
      end
    endcase
    if ($urandom_range(0, 3) == 0) dur = int'(cfg_limit) - 1 + int'($urandom_range(0, 2));
    else dur = int'($urandom_range(0, int'(cfg_limit) + int'(cfg_limit) / 4 + 2));
    if (dur < 0) dur = 0;
    if ($urandom_range(0, 9) == 0) tnow = 32'hFFFF_FFFF - 32'($urandom_range(0, 70000));
    else tnow = tnow + 32'($urandom_range(1, 500));
    t0 = tnow;
    send_touch(1'b1, sx, sy, t0);
    n_mid = int'($urandom_range(0, 3));
    for (k = 1; k <= n_mid; k++)
      send_touch(1'b1, sx + (ex - sx) * k / (n_mid + 1) + jitter(),
                 sy + (ey - sy) * k / (n_mid + 1) + jitter(),
                 t0 + 32'(dur * k / (n_mid + 1)));
    tnow = t0 + 32'(dur);
    send_touch(1'b0, ex, ey, tnow);
  endtask

  task automatic run_items(int n);
    int first;
    first = sent;
    while (sent - first < n) begin
      if ($urandom_range(0, 99) < 85) play_gesture();
      else send_touch(1'($urandom), int'($urandom_range(0, COORD_MAX)),
                      int'($urandom_range(0, COORD_MAX)), $urandom);
    end
  endtask

  // result side: checks every accepted item, stalls in bursts
  initial begin
    swipe_t want;
    int     stall_left;
    stall_left = 0;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
        if (pending_swipes.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd0, 32'(result.swipe_dir));
        end else begin
          want = pending_swipes.pop_front();
          if (result.swipe_dir !== want.dir)
            report_mismatch("swipe_dir", 32'(want.dir), 32'(result.swipe_dir));
          if (result.gesture_active !== want.active)
            report_mismatch("gesture_active", 32'(want.active), 32'(result.gesture_active));
        end
        results_seen++;
      end
      if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
        stall_left = int'($urandom_range(1, 15)) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  initial begin
    int i;
    mismatches   = 0;
    results_seen = 0;
    sent         = 0;
    idle_odds    = 10;
    line_pressed = 1'b0;
    tnow         = 32'd7000;
    cfg_width    = esgd_pkg::RESET_WIDTH;
    cfg_height   = esgd_pkg::RESET_HEIGHT;
    cfg_limit    = esgd_pkg::RESET_LIMIT;
    held_x       = '0;
    held_y       = '0;
    held_time    = '0;
    held_valid   = 1'b0;
    was_pressed  = 1'b0;
    rst           <= 1'b1;
    cfg.valid     <= 1'b0;
    cfg.index     <= esgd_pkg::REG_HRES;
    cfg.data      <= '0;
    touch.valid   <= 1'b0;
    touch.pressed <= 1'b0;
    touch.touch_x <= '0;
    touch.touch_y <= '0;
    touch.time_ms <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < NROWS; i++) drive_sample(PLAN[i].s, PLAN[i].typed, PLAN[i].want);
    line_pressed = PLAN[NROWS-1].s.pressed;

    set_registers(1, 1, 1);
    idle_odds = 10;
    run_items(150);
    set_registers(COORD_MAX, COORD_MAX, 65535);
    idle_odds = 20;
    run_items(250);
    set_registers(0, 0, int'($urandom_range(1, 2000)));
    idle_odds = 5;
    run_items(150);
    set_registers(int'($urandom_range(1, COORD_MAX)), int'($urandom_range(1, COORD_MAX)),
                  int'($urandom_range(1, 65535)));
    idle_odds = 10;
    run_items(350);
    set_registers(COORD_MAX, 1, 0);
    idle_odds = 15;
    run_items(150);
    set_registers(int'($urandom_range(16, 800)), int'($urandom_range(16, 800)),
                  int'($urandom_range(50, 3000)));
    idle_odds = 0;
    run_items(400);
    set_registers(320, 240, 400);
    run_items(250);

    touch.valid <= 1'b0;
    while (pending_swipes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("edge_swipe_gesture_detector regression: pass");
    end else begin
      $display("edge_swipe_gesture_detector regression: fail");
    end
    $finish;
  end

endmodule
